// File: sv/mcsd_pkg.sv
// Package for the message code stream decoder: defaults, byte codes and phase type.
package mcsd_pkg;

    // Default longest code length and width of the length field.
    localparam int MAX_CODE_LEN_DEF   = 7;
    localparam int LEN_FIELD_BITS_DEF = 3;

    // Byte codes with a meaning of their own.
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_HDR_START = 2'd0,
        PH_HDR_FILL  = 2'd1,
        PH_LEN       = 2'd2,
        PH_CODE      = 2'd3
    } phase_t;

    // True for a line break byte.
    function automatic logic is_break(input logic [7:0] b);
        return (b == CHAR_LF) || (b == CHAR_CR);
    endfunction

endpackage

// File: sv/mcsd_in_if.sv
// Input channel of the decoder: one raw stream byte per item.
interface mcsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// File: sv/mcsd_out_if.sv
// Output channel of the decoder: one decoded character per item.
interface mcsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;

    modport source (output valid, output out_char, input ready);
    modport sink   (input valid, input out_char, output ready);
endinterface

// File: sv/message_code_stream_decoder.sv
// Top level of the message code stream decoder.
//
// The decoder takes one stream byte in every cycle while its result register is
// empty or being emptied, and a decoded character appears in the result register
// in the cycle after the byte that completes its code. Header bytes fill a code
// table held in a single-port memory of 2^(MAX_CODE_LEN+1)-MAX_CODE_LEN-2 entries
// (247 by default), written one entry per byte; in message mode, a completed code
// reads that memory once, so the memory port sets the pace of one byte per cycle.
// Each new header clears all table entries at once through per-entry valid bits,
// so no clearing pass is needed; entries not written by the current header
// decode as 0. A zero length field emits a newline (10) and starts a new header.
module message_code_stream_decoder
    import mcsd_pkg::*;
#(
    parameter int MAX_CODE_LEN   = MAX_CODE_LEN_DEF,
    parameter int LEN_FIELD_BITS = LEN_FIELD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    mcsd_in_if.sink     in_stream,
    mcsd_out_if.source  out_stream
);

    // Sizes that follow from the parameters.
    localparam int TABLE_USED = (1 << (MAX_CODE_LEN + 1)) - MAX_CODE_LEN - 2;
    localparam int ADDR_W     = $clog2(TABLE_USED);
    localparam int FILL_W     = $clog2(TABLE_USED + 1);
    localparam int ACC_W      = (MAX_CODE_LEN > LEN_FIELD_BITS) ? MAX_CODE_LEN
                                                                : LEN_FIELD_BITS;
    localparam int CNT_W      = $clog2(ACC_W + 1);
    localparam int CL_W       = $clog2(MAX_CODE_LEN + 1);

    // Control state.
    phase_t              phase_reg, phase_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [CL_W-1:0]     code_len_reg, code_len_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TABLE_USED-1:0] entry_valid_reg;

    // Result register.
    logic                out_valid_reg;
    logic                nl_reg;
    logic                hit_valid_reg;
    logic [7:0]          rd_data_reg;

    // Code table memory.
    logic [7:0]          table_mem [TABLE_USED];

    // Per-item decode results.
    logic                accept;
    logic                wr_en;
    logic                clr_en;
    logic                rd_en;
    logic                emit_nl;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ACC_W-1:0]    acc_shift;
    logic [CNT_W-1:0]    cnt_inc;
    logic                in_brk;
    logic [7:0]          b;

    // Handshake: take a byte whenever the result register can take a result.
    assign in_stream.ready = !out_valid_reg || out_stream.ready;
    assign accept          = in_stream.valid && in_stream.ready;

    assign b         = in_stream.in_byte;
    assign in_brk    = is_break(b);
    assign acc_shift = {acc_reg[ACC_W-2:0], b[0]};
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    // The first byte of a header always goes to entry 0.
    assign wr_addr   = clr_en ? '0 : fill_reg[ADDR_W-1:0];

    // Next state for one accepted byte.
    always_comb
    begin
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        code_len_next = code_len_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        wr_en         = 1'b0;
        clr_en        = 1'b0;
        rd_en         = 1'b0;
        emit_nl       = 1'b0;
        rd_addr       = ADDR_W'((32'd1 << code_len_reg) - 32'(code_len_reg) - 32'd1
                                + 32'(acc_shift));
        case (phase_reg)
            PH_HDR_START:
            begin
                if (!in_brk)
                begin
                    // First header byte: clear the table and write entry 0.
                    clr_en    = 1'b1;
                    fill_next = FILL_W'(1);
                    acc_next  = '0;
                    cnt_next  = '0;
                    phase_next = (TABLE_USED <= 1) ? PH_LEN : PH_HDR_FILL;
                end
            end
            PH_HDR_FILL:
            begin
                if (in_brk)
                begin
                    phase_next = PH_LEN;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + FILL_W'(1);
                    if (fill_next >= FILL_W'(TABLE_USED))
                    begin
                        phase_next = PH_LEN;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
            end
            PH_LEN:
            begin
                if (!in_brk)
                begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_W'(LEN_FIELD_BITS))
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                        if (acc_shift == '0)
                        begin
                            // Zero length ends the message.
                            emit_nl    = 1'b1;
                            phase_next = PH_HDR_START;
                        end
                        else
                        begin
                            if (acc_shift > ACC_W'(MAX_CODE_LEN))
                            begin
                                code_len_next = CL_W'(MAX_CODE_LEN);
                            end
                            else
                            begin
                                code_len_next = CL_W'(acc_shift);
                            end
                            phase_next = PH_CODE;
                        end
                    end
                end
            end
            PH_CODE:
            begin
                if (!in_brk)
                begin
                    acc_next = acc_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= CNT_W'(code_len_reg))
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                        if (acc_shift == ACC_W'((32'd1 << code_len_reg) - 32'd1))
                        begin
                            // All-ones code ends the segment.
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_HDR_START;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR_START;
            fill_reg        <= '0;
            code_len_reg    <= '0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            entry_valid_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            code_len_reg <= code_len_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            if (clr_en)
            begin
                entry_valid_reg <= TABLE_USED'(1);
            end
            else if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Table memory: one write or one registered read per accepted byte.
    always_ff @(posedge clk)
    begin
        if (accept && (wr_en || clr_en))
        begin
            table_mem[wr_addr] <= b;
        end
        if (accept && rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            nl_reg        <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= rd_en || emit_nl;
            end
            else if (out_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && (rd_en || emit_nl))
            begin
                nl_reg        <= emit_nl;
                hit_valid_reg <= entry_valid_reg[rd_addr];
            end
        end
    end

    // Result output: newline, table character, or 0 for an unwritten entry.
    assign out_stream.valid    = out_valid_reg;
    assign out_stream.out_char = nl_reg ? CHAR_LF : (hit_valid_reg ? rd_data_reg : 8'd0);

endmodule
